>>> src/terrain_normal_packer_assert.svh
// Assertion macros shared by the terrain normal packer RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TERRAIN_NORMAL_PACKER_ASSERT_SVH
`define TERRAIN_NORMAL_PACKER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TNP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("terrain_normal_packer: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define TNP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("terrain_normal_packer: next-cycle check failed");

`endif

>>> src/tnp_pkg.sv
// Shared constants, types and helpers of the terrain normal packer.
// No dependencies.
package tnp_pkg;

  localparam int MaxCols  = 4096;
  localparam int MaxRows  = 4096;
  localparam int XyScale  = 1023;
  localparam int ZScale   = 1023;
  localparam int ElevBits = 24;
  localparam int LimitDim = 4096;

  localparam int IdxW   = 12;            // row and column index bits
  localparam int DimW   = 13;            // size register bits
  localparam int DiffW  = ElevBits + 1;  // elevation difference
  localparam int MagW   = ElevBits;      // magnitude of a difference
  localparam int WgtW   = 32;            // Q16.16 weights
  localparam int HalfW  = WgtW / 2;
  localparam int ProdW  = MagW + WgtW;
  localparam int FitW   = 30;
  localparam int SqW    = 2 * FitW;
  localparam int SumW   = SqW + 2;
  localparam int RemW   = SumW + 1;
  localparam int RootW  = FitW + 2;
  localparam int ScaleW = 10;
  localparam int NumW   = FitW + ScaleW;
  localparam int XFldW  = 11;
  localparam int ZFldW  = 10;
  localparam int NormW  = 2 * XFldW + ZFldW;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgGridWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGridHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRowWeight  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgColWeight  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFlatTerm   = 3'd4;

  localparam logic [DimW-1:0] ColTop = DimW'((MaxCols < LimitDim) ? MaxCols : LimitDim);
  localparam logic [DimW-1:0] RowTop = DimW'((MaxRows < LimitDim) ? MaxRows : LimitDim);

  typedef struct packed {
    logic signed [DiffW-1:0] dz1;
    logic signed [DiffW-1:0] dz2;
    logic [WgtW-1:0]         col_w;
    logic [WgtW-1:0]         row_w;
    logic [WgtW-1:0]         flat;
  } tnp_job_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] top);
    logic [DimW-1:0] r;
    if (v < DimW'(2)) r = DimW'(2);
    else if (v > top) r = top;
    else r = v;
    return r;
  endfunction

endpackage

>>> src/tnp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tnp_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/tnp_normal_unit.sv
// Iterative normal unit: weighting, range fit, root and division, packing.
// Depends on tnp_pkg and terrain_normal_packer_assert.svh.
module tnp_normal_unit import tnp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tnp_job_t         job_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NormW-1:0] normal_o
);

  localparam logic [2:0] UIdle   = 3'd0;
  localparam logic [2:0] UMul    = 3'd1;
  localparam logic [2:0] UShift  = 3'd2;
  localparam logic [2:0] USquare = 3'd3;
  localparam logic [2:0] URoot   = 3'd4;
  localparam logic [2:0] UDiv    = 3'd5;

  localparam logic [XFldW-1:0] XyField = XFldW'(XyScale);
  localparam logic [5:0] RootLast = 6'(RemW / 2);
  localparam logic [5:0] DivLast  = 6'(NumW - 1);

  logic [2:0]        state_q;
  logic [5:0]        cnt_q;
  logic [1:0]        sel_q;
  logic [MagW-1:0]   magx_q, magy_q;
  logic [WgtW-1:0]   cw_q, rw_q;
  logic              xneg_q, yneg_q;
  logic [ProdW-1:0]  ax_q, ay_q, az_q;
  logic [SumW-1:0]   sum_q;
  logic [RemW-1:0]   rem_q, root_q, bit_q;
  logic [RootW-1:0]  n_q;
  logic [NumW-1:0]   num_q;
  logic [RootW:0]    drem_q;
  logic [XFldW-1:0]  fx_q, fy_q;
  logic [NormW-1:0]  result_q;
  logic              done_q;

  // shared multiplier for the weighting steps
  logic [MagW-1:0]       mul_a;
  logic [HalfW-1:0]      mul_b;
  logic [WgtW-1:0]       mul_w;
  logic [MagW+HalfW-1:0] mul_p;
  logic [ProdW-1:0]      mul_s;

  assign mul_a = cnt_q[1] ? magy_q : magx_q;
  assign mul_w = cnt_q[1] ? rw_q : cw_q;
  assign mul_b = cnt_q[0] ? mul_w[WgtW-1:HalfW] : mul_w[HalfW-1:0];
  assign mul_p = mul_a * mul_b;
  assign mul_s = cnt_q[0] ? (ProdW'(mul_p) << HalfW) : ProdW'(mul_p);

  // squaring
  logic [FitW-1:0] sq_in;
  logic [SqW-1:0]  sq_p;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    sq_in = ax_q[FitW-1:0];
      2'd1:    sq_in = ay_q[FitW-1:0];
      default: sq_in = az_q[FitW-1:0];
    endcase
  end
  assign sq_p = sq_in * sq_in;

  logic over_fit;
  assign over_fit = (|ax_q[ProdW-1:FitW]) | (|ay_q[ProdW-1:FitW]) | (|az_q[ProdW-1:FitW]);

  // one root step
  logic [RemW-1:0] root_t, root_nx;
  logic            root_ge;
  assign root_t  = root_q + bit_q;
  assign root_ge = rem_q >= root_t;
  assign root_nx = root_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);

  // one division step
  logic [RootW:0]  div_t, drem_nx;
  logic            div_ge;
  logic [NumW-1:0] quo_nx;
  assign div_t   = {drem_q[RootW-1:0], num_q[NumW-1]};
  assign div_ge  = div_t >= {1'b0, n_q};
  assign drem_nx = div_ge ? (div_t - {1'b0, n_q}) : div_t;
  assign quo_nx  = {num_q[NumW-2:0], div_ge};

  // numerator of the next division run
  logic [FitW-1:0]   num_src;
  logic [ScaleW-1:0] num_scale;
  logic [NumW-1:0]   num_ld;
  logic [1:0]        num_sel;
  assign num_sel = (state_q == URoot) ? 2'd0 : sel_q + 2'd1;
  always_comb begin
    case (num_sel)
      2'd0:    begin num_src = ax_q[FitW-1:0]; num_scale = ScaleW'(XyScale); end
      2'd1:    begin num_src = ay_q[FitW-1:0]; num_scale = ScaleW'(XyScale); end
      default: begin num_src = az_q[FitW-1:0]; num_scale = ScaleW'(ZScale); end
    endcase
  end
  assign num_ld = NumW'(num_src) * NumW'(num_scale);

  // field of a finished run
  logic [XFldW-1:0] fld;
  logic             neg_sel;
  assign neg_sel = (sel_q == 2'd0) ? xneg_q : yneg_q;
  assign fld = neg_sel ? (XyField - (quo_nx[XFldW-1:0] + XFldW'(drem_nx != '0)))
                       : (XyField + quo_nx[XFldW-1:0]);

  logic [DiffW-1:0] neg1, neg2;
  assign neg1 = -job_i.dz1;
  assign neg2 = -job_i.dz2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UIdle;
      cnt_q   <= '0;
      sel_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        UIdle: begin
          if (start_i) begin
            state_q <= UMul;
            cnt_q   <= '0;
          end
        end
        UMul: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd3) begin
            state_q <= UShift;
          end
        end
        UShift: begin
          if (!over_fit) begin
            state_q <= USquare;
            cnt_q   <= '0;
          end
        end
        USquare: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd2) begin
            state_q <= URoot;
            cnt_q   <= '0;
          end
        end
        URoot: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == RootLast - 6'd1) begin
            state_q <= UDiv;
            cnt_q   <= '0;
            sel_q   <= '0;
          end
        end
        UDiv: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == DivLast) begin
            cnt_q <= '0;
            sel_q <= sel_q + 2'd1;
            if (sel_q == 2'd2) begin
              state_q <= UIdle;
              done_q  <= 1'b1;
            end
          end
        end
        default: state_q <= UIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      UIdle: begin
        if (start_i) begin
          magx_q <= job_i.dz1[DiffW-1] ? neg1[MagW-1:0] : job_i.dz1[MagW-1:0];
          magy_q <= job_i.dz2[DiffW-1] ? neg2[MagW-1:0] : job_i.dz2[MagW-1:0];
          xneg_q <= !job_i.dz1[DiffW-1] && (job_i.dz1 != '0);
          yneg_q <= job_i.dz2[DiffW-1];
          cw_q   <= job_i.col_w;
          rw_q   <= job_i.row_w;
          az_q   <= ProdW'(job_i.flat);
        end
      end
      UMul: begin
        case (cnt_q[1:0])
          2'd0:    ax_q <= mul_s;
          2'd1:    ax_q <= ax_q + mul_s;
          2'd2:    ay_q <= mul_s;
          default: ay_q <= ay_q + mul_s;
        endcase
      end
      UShift: begin
        if (over_fit) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
          az_q <= az_q >> 1;
        end
      end
      USquare: begin
        sum_q <= ((cnt_q == '0) ? '0 : sum_q) + SumW'(sq_p);
        rem_q  <= '0;
        root_q <= '0;
        // highest power of four the sum of three squares can reach
        bit_q  <= RemW'(1) << (2 * (RemW / 2 - 1));
        if (cnt_q == 6'd2) begin
          rem_q <= RemW'(sum_q + SumW'(sq_p));
        end
      end
      URoot: begin
        if (root_ge) begin
          rem_q <= rem_q - root_t;
        end
        root_q <= root_nx;
        bit_q  <= bit_q >> 2;
        n_q    <= (root_nx == '0) ? RootW'(1) : root_nx[RootW-1:0];
        num_q  <= num_ld;
        drem_q <= '0;
      end
      UDiv: begin
        num_q  <= quo_nx;
        drem_q <= drem_nx;
        if (cnt_q == DivLast) begin
          num_q  <= num_ld;
          drem_q <= '0;
          case (sel_q)
            2'd0:    fx_q <= fld;
            2'd1:    fy_q <= fld;
            default: result_q <= {fx_q, fy_q, quo_nx[ZFldW-1:0]};
          endcase
        end
      end
      default: ;
    endcase
  end

  assign busy_o   = state_q != UIdle;
  assign done_o   = done_q;
  assign normal_o = result_q;

  `include "terrain_normal_packer_assert.svh"

  `TNP_ASSERT_NXT(a_start_busy, start_i && !busy_o, busy_o)
  `TNP_ASSERT_IMP(a_div_nonzero, state_q == UDiv, n_q != '0)
  `TNP_ASSERT_IMP(a_fit_before_root, state_q == URoot, !over_fit)

endmodule

>>> src/terrain_normal_packer.sv
// Top level of the terrain normal packer: line buffers, sequencer, output register.
// Depends on tnp_pkg, tnp_ram, tnp_normal_unit and terrain_normal_packer_assert.svh.
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------------
//  input     in_valid_i/in_ready_o  elevation_i
//  output    out_valid_o/out_ready_i packed_normal_o cell_row_o cell_col_o
//                                   run_last_o grid_done_o
//  config    cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// A sample of the first grid row is written to the middle line buffer and gives no result.
// Any other sample passes the line buffer reads and write-back, then gives
// one normal (three on the last row's final column, two elsewhere on the last
// row except its first column); each normal is worked out in the iterative
// normal unit, whose main work is a 31-step root and three 40-step divisions.
// Reset clears the counters and the registers to their reset values; the line
// buffers hold no reset state. A stalled output holds the unit's result and
// the sequencer until the output register frees; the next sample is taken
// while the last result still waits.
module terrain_normal_packer import tnp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [ElevBits-1:0] elevation_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [NormW-1:0]           packed_normal_o,
  output logic [IdxW-1:0]            cell_row_o,
  output logic [IdxW-1:0]            cell_col_o,
  output logic                       run_last_o,
  output logic                       grid_done_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [WgtW-1:0]            cfg_data_i
);

  localparam logic [2:0] TIdle = 3'd0;
  localparam logic [2:0] TRd1  = 3'd1;
  localparam logic [2:0] TRd2  = 3'd2;
  localparam logic [2:0] TJob  = 3'd3;
  localparam logic [2:0] TRun  = 3'd4;
  localparam logic [2:0] TEmit = 3'd5;

  localparam logic [1:0] JobMain   = 2'd0;
  localparam logic [1:0] JobLeft   = 2'd1;
  localparam logic [1:0] JobCorner = 2'd2;

  logic [2:0]          state_q;
  logic [DimW-1:0]     wid_q, hgt_q;
  logic [WgtW-1:0]     rw_q, cw_q, flat_q;
  logic [IdxW-1:0]     row_q, col_q;
  logic [ElevBits-1:0] prev_q, s_q, mid_q, up_q, left_q, right_q;
  logic [IdxW-1:0]     r_q, c_q;
  logic                last_col_q, last_row_q;
  logic [1:0]          job_q;
  logic                out_valid_q, out_last_q, out_done_q;
  logic [NormW-1:0]    out_pn_q;
  logic [IdxW-1:0]     out_row_q, out_col_q;

  // current grid size and clamped position of the incoming sample
  logic [DimW-1:0] w_dim, h_dim;
  logic [IdxW-1:0] w_last, h_last, r_cl, c_cl;
  logic            lc, lr, accept;

  assign w_dim  = clamp_dim(wid_q, ColTop);
  assign h_dim  = clamp_dim(hgt_q, RowTop);
  assign w_last = IdxW'(w_dim - DimW'(1));
  assign h_last = IdxW'(h_dim - DimW'(1));
  assign r_cl   = (row_q > h_last) ? h_last : row_q;
  assign c_cl   = (col_q > w_last) ? w_last : col_q;
  assign lc     = c_cl == w_last;
  assign lr     = r_cl == h_last;

  assign in_ready_o = state_q == TIdle;
  assign accept     = in_valid_i && in_ready_o;

  // line buffers: middle holds the previous row, upper the one before it
  logic                mid_we, up_we;
  logic [IdxW-1:0]     mid_waddr, mid_raddr, up_raddr;
  logic [ElevBits-1:0] mid_wdata, mid_rdata, up_rdata;

  assign mid_we    = (accept && (r_cl == '0)) || (state_q == TRd2);
  assign mid_waddr = (state_q == TRd2) ? c_q : c_cl;
  assign mid_wdata = (state_q == TRd2) ? s_q : elevation_i;
  assign mid_raddr = (state_q == TRd1) ? c_q + IdxW'(1) : c_cl;
  assign up_we     = state_q == TRd2;
  assign up_raddr  = (state_q == TRd1) ? c_q - IdxW'(1) : c_cl;

  tnp_ram #(.Width(ElevBits), .Depth(MaxCols)) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (mid_we),
    .waddr_i (mid_waddr),
    .wdata_i (mid_wdata),
    .raddr_i (mid_raddr),
    .rdata_o (mid_rdata)
  );

  tnp_ram #(.Width(ElevBits), .Depth(MaxCols)) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (c_q),
    .wdata_i (mid_q),
    .raddr_i (up_raddr),
    .rdata_o (up_rdata)
  );

  function automatic logic signed [DiffW-1:0] sub_e(input logic [ElevBits-1:0] a,
                                                    input logic [ElevBits-1:0] b);
    return $signed({a[ElevBits-1], a}) - $signed({b[ElevBits-1], b});
  endfunction

  // differences and cell of the current normal
  tnp_job_t        job;
  logic [IdxW-1:0] cell_r, cell_c;
  always_comb begin
    job.col_w = cw_q;
    job.row_w = rw_q;
    job.flat  = flat_q;
    case (job_q)
      JobMain: begin
        cell_r = r_q - IdxW'(1);
        cell_c = c_q;
        if (r_q == IdxW'(1)) begin
          job.dz1 = last_col_q ? sub_e(mid_q, left_q) : sub_e(right_q, mid_q);
          job.dz2 = sub_e(s_q, mid_q);
        end else if (c_q == '0) begin
          job.dz1 = sub_e(right_q, mid_q);
          job.dz2 = sub_e(s_q, mid_q);
        end else if (!last_col_q) begin
          job.dz1 = sub_e(right_q, left_q);
          job.dz2 = sub_e(s_q, up_q);
        end else begin
          // last column of an inner row: single weights, one-sided column difference
          job.dz1 = sub_e(mid_q, left_q);
          job.dz2 = sub_e(s_q, up_q);
        end
      end
      JobLeft: begin
        cell_r  = r_q;
        cell_c  = c_q - IdxW'(1);
        job.dz1 = sub_e(s_q, prev_q);
        job.dz2 = sub_e(prev_q, left_q);
      end
      default: begin
        cell_r  = r_q;
        cell_c  = c_q;
        job.dz1 = sub_e(s_q, prev_q);
        job.dz2 = sub_e(s_q, mid_q);
      end
    endcase
  end

  // which normal follows the current one, if any
  logic       has_next;
  logic [1:0] next_job;
  always_comb begin
    has_next = 1'b0;
    next_job = JobCorner;
    case (job_q)
      JobMain: begin
        if (last_row_q && (c_q != '0)) begin
          has_next = 1'b1;
          next_job = JobLeft;
        end else if (last_row_q && last_col_q) begin
          has_next = 1'b1;
        end
      end
      JobLeft:  has_next = last_row_q && last_col_q;
      default:  has_next = 1'b0;
    endcase
  end

  logic             unit_start, unit_busy, unit_done;
  logic [NormW-1:0] unit_normal;
  assign unit_start = state_q == TJob;

  tnp_normal_unit u_normal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .job_i    (job),
    .busy_o   (unit_busy),
    .done_o   (unit_done),
    .normal_o (unit_normal)
  );

  logic out_load;
  assign out_load = (state_q == TEmit) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TIdle;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
      wid_q       <= DimW'(2);
      hgt_q       <= DimW'(2);
      rw_q        <= WgtW'(65536);
      cw_q        <= WgtW'(65536);
      flat_q      <= WgtW'(65536);
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end
      unique case (state_q)
        TIdle: begin
          if (accept) begin
            if (r_cl == '0) begin
              // first row: store and advance
              col_q <= lc ? '0 : c_cl + IdxW'(1);
              row_q <= (lc && !lr) ? r_cl + IdxW'(1) : ((lc && lr) ? '0 : r_cl);
            end else begin
              state_q <= TRd1;
            end
          end
        end
        TRd1: state_q <= TRd2;
        TRd2: state_q <= TJob;
        TJob: state_q <= TRun;
        TRun: begin
          if (unit_done) begin
            state_q <= TEmit;
          end
        end
        TEmit: begin
          if (out_load) begin
            if (has_next) begin
              state_q <= TJob;
            end else begin
              state_q <= TIdle;
              col_q   <= last_col_q ? '0 : c_q + IdxW'(1);
              row_q   <= (last_col_q && !last_row_q) ? r_q + IdxW'(1)
                       : ((last_col_q && last_row_q) ? '0 : r_q);
            end
          end
        end
        default: state_q <= TIdle;
      endcase
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgGridWidth: begin
            wid_q <= cfg_data_i[DimW-1:0];
            row_q <= '0;
            col_q <= '0;
          end
          CfgGridHeight: begin
            hgt_q <= cfg_data_i[DimW-1:0];
            row_q <= '0;
            col_q <= '0;
          end
          CfgRowWeight: rw_q   <= cfg_data_i;
          CfgColWeight: cw_q   <= cfg_data_i;
          CfgFlatTerm:  flat_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      TIdle: begin
        if (accept) begin
          s_q        <= elevation_i;
          r_q        <= r_cl;
          c_q        <= c_cl;
          last_col_q <= lc;
          last_row_q <= lr;
          job_q      <= JobMain;
          if (r_cl == '0) begin
            prev_q <= elevation_i;
          end
        end
      end
      TRd1: begin
        mid_q <= mid_rdata;
        up_q  <= up_rdata;
      end
      TRd2: begin
        right_q <= mid_rdata;
        left_q  <= up_rdata;
      end
      TEmit: begin
        if (out_load) begin
          if (has_next) begin
            job_q <= next_job;
          end else begin
            prev_q <= s_q;
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_pn_q   <= unit_normal;
      out_row_q  <= cell_r;
      out_col_q  <= cell_c;
      out_last_q <= !has_next;
      out_done_q <= job_q == JobCorner;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign packed_normal_o = out_pn_q;
  assign cell_row_o      = out_row_q;
  assign cell_col_o      = out_col_q;
  assign run_last_o      = out_last_q;
  assign grid_done_o     = out_done_q;

  `include "terrain_normal_packer_assert.svh"

  `TNP_ASSERT_IMP(a_start_when_free, unit_start, !unit_busy)
  `TNP_ASSERT_IMP(a_done_is_last, out_valid_o && grid_done_o, run_last_o)
  `TNP_ASSERT_IMP(a_writeback_inner, state_q == TRd2, r_q != '0)

endmodule

>>> bench/tb_top.sv
// Self-checking bench for terrain_normal_packer: streams elevation grids, predicts each normal.
// Depends on tnp_pkg and the terrain_normal_packer RTL; needs nothing else.
module tb_top;
  import tnp_pkg::*;

  // Index past the register list; the block must ignore a write to it.
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd5;
  // Normals that can be read off directly: a flat patch with unit weights, and a zero vector.
  localparam logic [NormW-1:0] FlatNormal = 32'h7FEF_FFFF;
  localparam logic [NormW-1:0] ZeroNormal = 32'h7FEF_FC00;
  // Cycles to let the iterative normal unit run dry before a register write.
  localparam int DrainCycles = 700;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [ElevBits-1:0] elevation_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [NormW-1:0]           packed_normal_o;
  logic [IdxW-1:0]            cell_row_o;
  logic [IdxW-1:0]            cell_col_o;
  logic                       run_last_o;
  logic                       grid_done_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxW-1:0]         cfg_index_i = '0;
  logic [WgtW-1:0]            cfg_data_i = '0;

  terrain_normal_packer dut (.*);

  always #5 clk_i = ~clk_i;

  // One emitted normal as the block should present it.
  typedef struct {
    logic [NormW-1:0] normal;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic             last;
    logic             done;
  } normal_t;

  // One line of the directed plan: either a register write or a sample.
  typedef struct {
    bit                         is_cfg;
    logic [CfgIdxW-1:0]         idx;
    logic [WgtW-1:0]            data;
    logic signed [ElevBits-1:0] elev;
    bit                         typed;
    logic [NormW-1:0]           normal;
  } plan_row_t;

  normal_t pending_normals[$];
  int      fail_count = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;

  // Shadow of the block: line buffers, raster position and registers.
  longint          upper_row[MaxCols];
  longint          middle_row[MaxCols];
  int unsigned     row_pos, col_pos;
  longint          prev_elev;
  logic [DimW-1:0] width_reg, height_reg;
  logic [WgtW-1:0] row_w, col_w, flat_w;

  function automatic int unsigned eff_dim(logic [DimW-1:0] v);
    if (v < 2) return 2;
    if (v > LimitDim) return LimitDim;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Offset-binary axis field: round away from the center for negative components.
  function automatic logic [XFldW-1:0] axis_field(longint unsigned a, bit neg,
                                                  longint unsigned n);
    longint unsigned p, q;
    p = a * XyScale;
    q = p / n;
    if (neg) begin
      if (p % n != 0) q++;
      return XFldW'(XyScale - q);
    end
    return XFldW'(XyScale + q);
  endfunction

  function automatic logic [NormW-1:0] surface_normal(longint dz1, longint dz2);
    longint unsigned ax, ay, az, top, n;
    int sh;
    ax = (dz1 < 0 ? -dz1 : dz1) * longint'(col_w);
    ay = (dz2 < 0 ? -dz2 : dz2) * longint'(row_w);
    az = flat_w;
    top = ax > ay ? ax : ay;
    if (az > top) top = az;
    sh = 0;
    while ((top >> sh) >= (64'd1 << FitW)) sh++;
    ax >>= sh;
    ay >>= sh;
    az >>= sh;
    n = floor_root(ax * ax + ay * ay + az * az);
    if (n == 0) n = 1;
    return {axis_field(ax, dz1 > 0, n), axis_field(ay, dz2 < 0, n),
            ZFldW'((az * ZScale) / n)};
  endfunction

  function automatic void push_normal(logic [NormW-1:0] nv, int unsigned r, int unsigned c,
                                      bit done);
    normal_t e;
    e.normal = nv;
    e.row = IdxW'(r);
    e.col = IdxW'(c);
    e.last = 1'b0;
    e.done = done;
    pending_normals.push_back(e);
  endfunction

  // Advance the shadow by one accepted sample and queue the normals it causes.
  function automatic void predict_sample(logic signed [ElevBits-1:0] elev);
    int unsigned w, h, r, c, p, first;
    longint s, mid, up, left, right, dz1, dz2;
    bit last_col;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    s = elev;
    r = row_pos >= h ? h - 1 : row_pos;
    c = col_pos >= w ? w - 1 : col_pos;
    last_col = (c == w - 1);
    first = pending_normals.size();
    if (r == 0) begin
      middle_row[c] = s;
    end else begin
      p = r - 1;
      mid = middle_row[c];
      up = upper_row[c];
      left = c > 0 ? upper_row[c-1] : 0;
      right = last_col ? 0 : middle_row[c+1];
      if (p == 0) begin
        dz1 = last_col ? mid - left : right - mid;
        dz2 = s - mid;
      end else if (c == 0) begin
        dz1 = right - mid;
        dz2 = s - mid;
      end else begin
        // Last column of inner rows keeps the one-sided row difference.
        dz1 = last_col ? mid - left : right - left;
        dz2 = s - up;
      end
      push_normal(surface_normal(dz1, dz2), p, c, 1'b0);
      upper_row[c] = mid;
      middle_row[c] = s;
      // Last row trails by one column; the final sample also closes its own cell.
      if (r == h - 1) begin
        if (c >= 1)
          push_normal(surface_normal(s - prev_elev, prev_elev - upper_row[c-1]), r, c - 1,
                      1'b0);
        if (last_col)
          push_normal(surface_normal(s - prev_elev, s - upper_row[c]), r, c, 1'b1);
      end
    end
    prev_elev = s;
    if (last_col) begin
      col_pos = 0;
      row_pos = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    if (pending_normals.size() > first)
      pending_normals[pending_normals.size() - 1].last = 1'b1;
  endfunction

  function automatic void predict_write(logic [CfgIdxW-1:0] idx, logic [WgtW-1:0] data);
    case (idx)
      CfgGridWidth: begin
        width_reg = DimW'(data);
        row_pos = 0;
        col_pos = 0;
      end
      CfgGridHeight: begin
        height_reg = DimW'(data);
        row_pos = 0;
        col_pos = 0;
      end
      CfgRowWeight: row_w = data;
      CfgColWeight: col_w = data;
      CfgFlatTerm:  flat_w = data;
      default: ;
    endcase
  endfunction

  // Drop the input valid, wait for every queued normal, then let the unit run dry.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [WgtW-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    predict_write(idx, data);
  endtask

  // Offer one sample, with an occasional sender gap, and predict on acceptance.
  task automatic send_elev(logic signed [ElevBits-1:0] elev);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elevation_i <= elev;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample(elev);
  endtask

  function automatic logic signed [ElevBits-1:0] pick_elev();
    case ($urandom_range(3))
      0: return ElevBits'($urandom);
      1: return ElevBits'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(1) ? 24'sh7F_FFFF : 24'sh80_0000;
      default: return ElevBits'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    endcase
  endfunction

  function automatic logic [WgtW-1:0] pick_weight();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // Receiver side: stall at the rate of the current idling phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every accepted normal against the oldest prediction.
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_normals.size() == 0) begin
        $error("unexpected normal %h at row %0d col %0d", packed_normal_o, cell_row_o,
               cell_col_o);
        fail_count++;
      end else begin
        e = pending_normals.pop_front();
        if (packed_normal_o !== e.normal) begin
          $error("packed_normal: expected %h, got %h", e.normal, packed_normal_o);
          fail_count++;
        end
        if (cell_row_o !== e.row) begin
          $error("cell_row: expected %0d, got %0d", e.row, cell_row_o);
          fail_count++;
        end
        if (cell_col_o !== e.col) begin
          $error("cell_col: expected %0d, got %0d", e.col, cell_col_o);
          fail_count++;
        end
        if (run_last_o !== e.last) begin
          $error("run_last: expected %0d, got %0d", e.last, run_last_o);
          fail_count++;
        end
        if (grid_done_o !== e.done) begin
          $error("grid_done: expected %0d, got %0d", e.done, grid_done_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #35_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    plan_row_t plan[$];
    int unsigned sent, w, h, count, first, phase;
    bit resize;

    // Directed plan: flat 2x2 patch at reset weights, a zero-vector patch of extreme
    // elevations, then an extreme-weight 3x3 patch checked by the predictor alone.
    plan = '{
      '{0, CfgSpare, 0, 24'sd0, 1, FlatNormal}, '{0, CfgSpare, 0, 24'sd0, 1, FlatNormal},
      '{0, CfgSpare, 0, 24'sd0, 1, FlatNormal}, '{0, CfgSpare, 0, 24'sd0, 1, FlatNormal},
      '{1, CfgSpare, 32'h1234_5678, 24'sd0, 0, '0},
      '{1, CfgRowWeight, 0, 24'sd0, 0, '0}, '{1, CfgColWeight, 0, 24'sd0, 0, '0},
      '{1, CfgFlatTerm, 0, 24'sd0, 0, '0},
      '{0, CfgSpare, 0, 24'sh7F_FFFF, 1, ZeroNormal},
      '{0, CfgSpare, 0, 24'sh80_0000, 1, ZeroNormal},
      '{0, CfgSpare, 0, 24'sh80_0000, 1, ZeroNormal},
      '{0, CfgSpare, 0, 24'sh7F_FFFF, 1, ZeroNormal},
      '{1, CfgRowWeight, '1, 24'sd0, 0, '0}, '{1, CfgColWeight, '1, 24'sd0, 0, '0},
      '{1, CfgFlatTerm, '1, 24'sd0, 0, '0},
      '{1, CfgGridWidth, 3, 24'sd0, 0, '0}, '{1, CfgGridHeight, 3, 24'sd0, 0, '0},
      '{0, CfgSpare, 0, 24'sh7F_FFFF, 0, '0}, '{0, CfgSpare, 0, 24'sh80_0000, 0, '0},
      '{0, CfgSpare, 0, 24'sd1, 0, '0}, '{0, CfgSpare, 0, -24'sd1, 0, '0},
      '{0, CfgSpare, 0, 24'sh7F_FFFF, 0, '0}, '{0, CfgSpare, 0, 24'sd0, 0, '0},
      '{0, CfgSpare, 0, 24'sh80_0000, 0, '0}, '{0, CfgSpare, 0, 24'sh55_AAAA, 0, '0},
      '{0, CfgSpare, 0, 24'sh2A_5555, 0, '0}
    };

    // Hold the shadow at its reset values, then release reset.
    row_pos = 0;
    col_pos = 0;
    prev_elev = 0;
    width_reg = 2;
    height_reg = 2;
    row_w = 32'h1_0000;
    col_w = 32'h1_0000;
    flat_w = 32'h1_0000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 17;
    rx_idle_pct = 63;
    sent = 0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        first = pending_normals.size();
        send_elev(plan[i].elev);
        sent++;
        if (plan[i].typed)
          for (int k = first; k < pending_normals.size(); k++)
            if (pending_normals[k].normal !== plan[i].normal) begin
              $error("packed_normal: expected %h, got %h", plan[i].normal,
                     pending_normals[k].normal);
              fail_count++;
            end
      end
    end

    // Random part: grids of random size and weights; first third sender-light idling,
    // then the other way round, then no idling at all.
    phase = 0;
    while (sent < 460) begin
      if (sent > 310) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (sent > 160) begin
        tx_idle_pct = 63;
        rx_idle_pct = 17;
      end
      resize = (phase < 6) || ($urandom_range(3) != 0);
      if (phase == 2) begin
        // Widest grid: stream only part of the first row, which causes no normal.
        write_reg(CfgGridWidth, 32'h1FFF);
        write_reg(CfgGridHeight, 2);
        count = 20;
      end else if (phase == 4) begin
        // Tallest grid with the narrowest width: stream a few rows, then abandon it.
        write_reg(CfgGridWidth, 0);
        write_reg(CfgGridHeight, 32'hFFFF_FFFF);
        count = 8;
      end else begin
        if (resize) begin
          write_reg(CfgGridWidth, $urandom_range(9) == 0 ? $urandom_range(1) :
                                  $urandom_range(2, 6));
          write_reg(CfgGridHeight, $urandom_range(9) == 0 ? $urandom_range(1) :
                                   $urandom_range(2, 5));
        end
        write_reg(CfgRowWeight, pick_weight());
        write_reg(CfgColWeight, pick_weight());
        write_reg(CfgFlatTerm, pick_weight());
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        count = $urandom_range(1, 2) * w * h;
        // Leave some grids unfinished so weights change mid-grid.
        if ($urandom_range(3) == 0) count = $urandom_range(1, count);
      end
      repeat (count) begin
        send_elev(pick_elev());
        sent++;
      end
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
